// ===== rtl/core/lfpd_pkg.sv =====
// Shared types, codes and limits for the line-follow PD motor drive.
// Used by every module of the block; depends on nothing.
package lfpd_pkg;

    // Item kinds carried on the input channel.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_MANUAL = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_GAIN_P      = 3'd0;
    localparam logic [2:0] CFG_GAIN_D      = 3'd1;
    localparam logic [2:0] CFG_CRUISE      = 3'd2;
    localparam logic [2:0] CFG_BIAS_LEFT   = 3'd3;
    localparam logic [2:0] CFG_BIAS_CENTRE = 3'd4;
    localparam logic [2:0] CFG_BIAS_RIGHT  = 3'd5;

    // Motor select code that picks motor A for a manual speed.
    localparam logic [7:0] MOTOR_SEL_A = 8'd2;

    // Limits of the control law.
    localparam int SENSE_MAX  = 100;
    localparam int ERR_LIMIT  = 30;
    localparam int LINE_LIMIT = 150;
    localparam int DRIVE_MAX  = 255;

    // Result of the sensor front end for one sample.
    typedef struct packed {
        logic              line;
        logic signed [6:0] err;
    } sense_t;

    // Drive outputs of one motor.
    typedef struct packed {
        logic       dir;
        logic [7:0] pwm;
    } motor_t;

endpackage

// ===== rtl/core/line_follow_pd_motor_drive.sv =====
// Top level of the line-follow PD motor drive: input register, PD law, result register.
// Depends on lfpd_pkg, lfpd_sense and lfpd_drive.
//
// Usage:
// The input channel (in_valid/in_ready) takes one beat per item: a sensor sample,
// a manual speed write or a stop/go command. The output channel (out_valid/out_ready)
// delivers one beat for each sensor sample and each stop/go command; manual speed
// writes and the unused kind give no beat. The configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and writes one register
// per beat; it is meant to be used while the block is idle.
// A result passes through the input register, then the result register, before it is on
// the output. Throughput: one item per cycle while the receiver takes results, set by the
// single combinational pass from the input register to the result register.
// When the receiver stalls, the result register holds its beat, the input register
// keeps one more item, and in_ready drops only once both are full.
// Reset clears the control state, the gains to zero, cruise speed to 50 and the
// biases to 3, 0 and -2; no clearing pass is needed.
module line_follow_pd_motor_drive
    import lfpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [9:0]         sensor_left,
    input  logic [9:0]         sensor_centre,
    input  logic [9:0]         sensor_right,
    input  logic [7:0]         motor_select,
    input  logic signed [15:0] manual_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               dir_a,
    output logic [7:0]         pwm_a,
    output logic               dir_b,
    output logic [7:0]         pwm_b,
    output logic               line_mode,
    output logic               stop_report,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Configuration registers.
    logic signed [15:0] gain_p_reg;
    logic signed [15:0] gain_d_reg;
    logic signed [15:0] cruise_reg;
    logic signed [7:0]  bias_left_reg;
    logic signed [7:0]  bias_centre_reg;
    logic signed [7:0]  bias_right_reg;

    // Control state.
    logic signed [6:0]  prev_error_reg;
    logic               report_done_reg;
    logic signed [15:0] manual_a_reg;
    logic signed [15:0] manual_b_reg;

    // Input register.
    logic               s1_valid_reg;
    logic [1:0]         s1_kind_reg;
    logic [9:0]         s1_left_reg;
    logic [9:0]         s1_centre_reg;
    logic [9:0]         s1_right_reg;
    logic [7:0]         s1_select_reg;
    logic signed [15:0] s1_value_reg;

    // Result register.
    logic               out_valid_reg;
    motor_t             motor_a_reg;
    motor_t             motor_b_reg;
    logic               line_reg;
    logic               report_reg;

    logic               in_fire;
    logic               s1_fire;
    logic               s1_result;
    logic               s1_valid_next;
    logic               out_valid_next;
    sense_t             sense;
    logic signed [15:0] err_ext;
    logic signed [7:0]  derr;
    logic signed [15:0] derr_ext;
    logic signed [15:0] p_prod;
    logic signed [15:0] d_prod;
    logic signed [15:0] corr;
    logic signed [15:0] sum_a;
    logic signed [15:0] sum_b;
    logic signed [15:0] line_a;
    logic signed [15:0] line_b;
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    motor_t             drive_a;
    motor_t             drive_b;
    motor_t             motor_a_next;
    motor_t             motor_b_next;
    logic               line_next;
    logic               report_next;

    // Handshake: the input register moves on whenever the result slot is free.
    assign cfg_ready = 1'b1;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_result = (s1_kind_reg == KIND_SAMPLE) || (s1_kind_reg == KIND_STOP);
    assign in_ready  = !s1_valid_reg || s1_fire;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Sensor front end.
    lfpd_sense u_sense
    (
        .sensor_left   (s1_left_reg),
        .sensor_centre (s1_centre_reg),
        .sensor_right  (s1_right_reg),
        .bias_left     (bias_left_reg),
        .bias_centre   (bias_centre_reg),
        .bias_right    (bias_right_reg),
        .sense         (sense)
    );

    // PD correction in 16-bit wrapping arithmetic; only the low product bits are kept.
    assign err_ext  = {{9{sense.err[6]}}, sense.err};
    assign derr     = {sense.err[6], sense.err} - {prev_error_reg[6], prev_error_reg};
    assign derr_ext = {{8{derr[7]}}, derr};
    assign p_prod   = err_ext * gain_p_reg;
    assign d_prod   = derr_ext * gain_d_reg;
    assign corr     = p_prod + d_prod;
    assign sum_a    = cruise_reg + corr;
    assign sum_b    = cruise_reg - corr;

    // Line speeds are limited before they reach the drive stage.
    always_comb
    begin
        if (sum_a < -LINE_LIMIT)
            line_a = -16'(LINE_LIMIT);
        else if (sum_a > LINE_LIMIT)
            line_a = 16'(LINE_LIMIT);
        else
            line_a = sum_a;
        if (sum_b < -LINE_LIMIT)
            line_b = -16'(LINE_LIMIT);
        else if (sum_b > LINE_LIMIT)
            line_b = 16'(LINE_LIMIT);
        else
            line_b = sum_b;
    end

    // A stop/go command drives zero; a sample off the line drives the manual speeds.
    always_comb
    begin
        if (s1_kind_reg == KIND_STOP)
        begin
            speed_a = '0;
            speed_b = '0;
        end
        else if (sense.line)
        begin
            speed_a = line_a;
            speed_b = line_b;
        end
        else
        begin
            speed_a = manual_a_reg;
            speed_b = manual_b_reg;
        end
    end

    lfpd_drive u_drive_a
    (
        .speed (speed_a),
        .motor (drive_a)
    );

    lfpd_drive u_drive_b
    (
        .speed (speed_b),
        .motor (drive_b)
    );

    // Result beat contents.
    always_comb
    begin
        motor_a_next = drive_a;
        motor_b_next = drive_b;
        line_next    = 1'b0;
        report_next  = 1'b0;
        if (s1_kind_reg == KIND_SAMPLE)
        begin
            line_next   = sense.line;
            report_next = !sense.line && !report_done_reg;
        end
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg      <= 16'sd0;
            gain_d_reg      <= 16'sd0;
            cruise_reg      <= 16'sd50;
            bias_left_reg   <= 8'sd3;
            bias_centre_reg <= 8'sd0;
            bias_right_reg  <= -8'sd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                CFG_CRUISE:      cruise_reg      <= cfg_data;
                CFG_BIAS_LEFT:   bias_left_reg   <= cfg_data[7:0];
                CFG_BIAS_CENTRE: bias_centre_reg <= cfg_data[7:0];
                CFG_BIAS_RIGHT:  bias_right_reg  <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Control state advances as each item leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg  <= '0;
            report_done_reg <= 1'b0;
            manual_a_reg    <= '0;
            manual_b_reg    <= '0;
        end
        else if (s1_fire)
        begin
            case (s1_kind_reg)
                KIND_SAMPLE:
                begin
                    prev_error_reg  <= sense.err;
                    report_done_reg <= !sense.line;
                end
                KIND_MANUAL:
                begin
                    if (s1_select_reg == MOTOR_SEL_A)
                        manual_a_reg <= s1_value_reg;
                    else
                        manual_b_reg <= s1_value_reg;
                end
                KIND_STOP:
                begin
                    manual_a_reg <= '0;
                    manual_b_reg <= '0;
                end
                default:     ;
            endcase
        end
    end

    // Valid flags of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg   <= kind;
            s1_left_reg   <= sensor_left;
            s1_centre_reg <= sensor_centre;
            s1_right_reg  <= sensor_right;
            s1_select_reg <= motor_select;
            s1_value_reg  <= manual_value;
        end
    end

    // Payload of the result register.
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_result)
        begin
            motor_a_reg <= motor_a_next;
            motor_b_reg <= motor_b_next;
            line_reg    <= line_next;
            report_reg  <= report_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign dir_a       = motor_a_reg.dir;
    assign pwm_a       = motor_a_reg.pwm;
    assign dir_b       = motor_b_reg.dir;
    assign pwm_b       = motor_b_reg.pwm;
    assign line_mode   = line_reg;
    assign stop_report = report_reg;

    // An empty input register always takes a beat.
    assert property (@(posedge clk) disable iff (!rst_n) !s1_valid_reg |-> in_ready)
        else $error("input register empty but in_ready low");

    // A stop report is only given off the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_report |-> !line_mode)
        else $error("stop report raised in line mode");

    // Line speeds are limited, so the duty cannot drop below the line floor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_mode |-> (pwm_a >= 8'd105) && (pwm_b >= 8'd105))
        else $error("line mode duty beyond the line speed limit");

    // A sample off the line leaves the report marked as done.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_kind_reg == KIND_SAMPLE) && !sense.line |=> report_done_reg)
        else $error("report state not set after leaving the line");

endmodule

// ===== rtl/core/lfpd_sense.sv =====
// Sensor front end: bias removal, reading clamps and the clamped line error.
// Depends on lfpd_pkg.
module lfpd_sense
    import lfpd_pkg::*;
(
    input  logic [9:0]        sensor_left,
    input  logic [9:0]        sensor_centre,
    input  logic [9:0]        sensor_right,
    input  logic signed [7:0] bias_left,
    input  logic signed [7:0] bias_centre,
    input  logic signed [7:0] bias_right,
    output sense_t            sense
);

    // Subtract the signed bias and clamp the reading to 0..SENSE_MAX.
    function automatic logic [6:0] clamp_reading(input logic [9:0] raw,
                                                 input logic signed [7:0] bias);
        logic signed [11:0] diff;
        diff = $signed({2'b00, raw}) - $signed({{4{bias[7]}}, bias});
        if (diff < 0)
            return 7'd0;
        else if (diff > SENSE_MAX)
            return 7'(SENSE_MAX);
        else
            return diff[6:0];
    endfunction

    logic [6:0]        level_left;
    logic [6:0]        level_centre;
    logic [6:0]        level_right;
    logic signed [7:0] raw_err;

    assign level_left   = clamp_reading(sensor_left, bias_left);
    assign level_centre = clamp_reading(sensor_centre, bias_centre);
    assign level_right  = clamp_reading(sensor_right, bias_right);

    // Left minus right, clamped to the error limit.
    assign raw_err = $signed({1'b0, level_left}) - $signed({1'b0, level_right});

    always_comb
    begin
        if (raw_err < -ERR_LIMIT)
            sense.err = -7'(ERR_LIMIT);
        else if (raw_err > ERR_LIMIT)
            sense.err = 7'(ERR_LIMIT);
        else
            sense.err = raw_err[6:0];
        sense.line = (level_centre == 7'(SENSE_MAX));
    end

endmodule

// ===== rtl/core/lfpd_drive.sv =====
// Motor drive stage: clamps a speed to the drive range and forms direction and duty.
// Depends on lfpd_pkg.
module lfpd_drive
    import lfpd_pkg::*;
(
    input  logic signed [15:0] speed,
    output motor_t             motor
);

    logic [7:0] magnitude;

    // The magnitude saturates at the drive limit in either direction.
    always_comb
    begin
        if (speed < -DRIVE_MAX || speed > DRIVE_MAX)
            magnitude = 8'(DRIVE_MAX);
        else if (speed[15])
            magnitude = 8'(-speed);
        else
            magnitude = speed[7:0];
        motor.dir = !speed[15];
        motor.pwm = 8'(DRIVE_MAX) - magnitude;
    end

endmodule

// ===== dv/line_follow_pd_motor_drive_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_follow_pd_motor_drive: directed and random beats,
// with a built-in predictor of the PD law and drive stage. Depends on lfpd_pkg and the RTL.
module line_follow_pd_motor_drive_tb;
    import lfpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 6;
    localparam int IDLE_PERCENT   = 21;
    localparam int PHASE_ITEMS    = 55;

    // Register indexes past the end of the list; writes there must be ignored.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // One expected result beat.
    typedef struct packed {
        logic       dir_a;
        logic [7:0] pwm_a;
        logic       dir_b;
        logic [7:0] pwm_b;
        logic       line_mode;
        logic       stop_report;
    } drive_beat_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [1:0]         kind          = KIND_SAMPLE;
    logic [9:0]         sensor_left   = '0;
    logic [9:0]         sensor_centre = '0;
    logic [9:0]         sensor_right  = '0;
    logic [7:0]         motor_select  = '0;
    logic signed [15:0] manual_value  = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic               dir_a;
    logic [7:0]         pwm_a;
    logic               dir_b;
    logic [7:0]         pwm_b;
    logic               line_mode;
    logic               stop_report;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index     = CFG_GAIN_P;
    logic [15:0]        cfg_data      = '0;

    // Predictor copy of the settings and control state.
    logic signed [15:0] kp          = 16'sd0;
    logic signed [15:0] kd          = 16'sd0;
    logic signed [15:0] cruise      = 16'sd50;
    int                 bias_l      = 3;
    int                 bias_c      = 0;
    int                 bias_r      = -2;
    int                 last_err    = 0;
    logic               stop_given  = 1'b0;
    int                 man_speed_a = 0;
    int                 man_speed_b = 0;

    drive_beat_t expected_drive[$];
    int          error_count    = 0;
    int          stalled_cycles = 0;
    logic        idle_on        = 1'b1;
    int          holds_asked    = 0;
    int          holds_done     = 0;
    int          hold_left      = 0;

    line_follow_pd_motor_drive uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .sensor_left   (sensor_left),
        .sensor_centre (sensor_centre),
        .sensor_right  (sensor_right),
        .motor_select  (motor_select),
        .manual_value  (manual_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dir_a         (dir_a),
        .pwm_a         (pwm_a),
        .dir_b         (dir_b),
        .pwm_b         (pwm_b),
        .line_mode     (line_mode),
        .stop_report   (stop_report),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Drive stage of one motor: clamp, direction, inverted duty.
    function automatic motor_t motor_cmd(input int speed);
        motor_t m;
        int     s;
        s     = clamp_int(speed, -DRIVE_MAX, DRIVE_MAX);
        m.dir = (s >= 0);
        m.pwm = 8'(DRIVE_MAX - ((s < 0) ? -s : s));
        return m;
    endfunction

    function automatic drive_beat_t drive_beat(input int sa, input int sb, input logic line,
                                               input logic report);
        drive_beat_t b;
        motor_t      ma;
        motor_t      mb;
        ma            = motor_cmd(sa);
        mb            = motor_cmd(sb);
        b.dir_a       = ma.dir;
        b.pwm_a       = ma.pwm;
        b.dir_b       = mb.dir;
        b.pwm_b       = mb.pwm;
        b.line_mode   = line;
        b.stop_report = report;
        return b;
    endfunction

    // Works out the result of the input beat now on the ports and updates the state.
    task automatic predict_item();
        int                 l;
        int                 c;
        int                 r;
        int                 err;
        logic signed [15:0] pterm;
        logic signed [15:0] dterm;
        logic signed [15:0] corr;
        logic signed [15:0] sum_a;
        logic signed [15:0] sum_b;
        logic               line;
        logic               report;
        case (kind)
            KIND_MANUAL:
            begin
                if (motor_select == MOTOR_SEL_A)
                    man_speed_a = int'(manual_value);
                else
                    man_speed_b = int'(manual_value);
            end
            KIND_STOP:
            begin
                man_speed_a = 0;
                man_speed_b = 0;
                expected_drive.push_back(drive_beat(0, 0, 1'b0, 1'b0));
            end
            KIND_SAMPLE:
            begin
                l      = clamp_int(int'(sensor_left) - bias_l, 0, SENSE_MAX);
                c      = clamp_int(int'(sensor_centre) - bias_c, 0, SENSE_MAX);
                r      = clamp_int(int'(sensor_right) - bias_r, 0, SENSE_MAX);
                err    = clamp_int(l - r, -ERR_LIMIT, ERR_LIMIT);
                pterm  = 16'(err * int'(kp));
                dterm  = 16'((err - last_err) * int'(kd));
                corr   = pterm + dterm;
                line   = (c >= SENSE_MAX);
                report = 1'b0;
                last_err = err;
                if (line)
                begin
                    sum_a      = cruise + corr;
                    sum_b      = cruise - corr;
                    stop_given = 1'b0;
                    expected_drive.push_back(drive_beat(
                        clamp_int(int'(sum_a), -LINE_LIMIT, LINE_LIMIT),
                        clamp_int(int'(sum_b), -LINE_LIMIT, LINE_LIMIT), 1'b1, 1'b0));
                end
                else
                begin
                    report     = !stop_given;
                    stop_given = 1'b1;
                    expected_drive.push_back(drive_beat(man_speed_a, man_speed_b, 1'b0,
                                                        report));
                end
            end
            default:
            begin
                // The unused kind leaves everything as it was.
            end
        endcase
    endtask

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Monitor: settings writes, predictions and result checks, all on the edge.
    always @(posedge clk)
    begin
        drive_beat_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_P:      kp = $signed(cfg_data);
                    CFG_GAIN_D:      kd = $signed(cfg_data);
                    CFG_CRUISE:      cruise = $signed(cfg_data);
                    CFG_BIAS_LEFT:   bias_l = int'($signed(cfg_data[7:0]));
                    CFG_BIAS_CENTRE: bias_c = int'($signed(cfg_data[7:0]));
                    CFG_BIAS_RIGHT:  bias_r = int'($signed(cfg_data[7:0]));
                    default:
                    begin
                        // Spare indexes hold nothing.
                    end
                endcase
            end
            if (in_valid && in_ready)
                predict_item();
            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                    report_error("result beat with no expectation waiting");
                else
                begin
                    want = expected_drive.pop_front();
                    check_field("dir_a", dir_a, want.dir_a);
                    check_field("pwm_a", pwm_a, want.pwm_a);
                    check_field("dir_b", dir_b, want.dir_b);
                    check_field("pwm_b", pwm_b, want.pwm_b);
                    check_field("line_mode", line_mode, want.line_mode);
                    check_field("stop_report", stop_report, want.stop_report);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_asked != holds_done)
        begin
            out_ready  <= 1'b0;
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
        end
        else
            out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: ends the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", stalled_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one input beat, after a random gap when idling is on, and returns on the edge that takes it.
    task automatic send_item(input logic [1:0] k, input logic [9:0] s_left,
                             input logic [9:0] s_centre, input logic [9:0] s_right,
                             input logic [7:0] sel, input logic [15:0] value);
        while (idle_on && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        sensor_left   <= s_left;
        sensor_centre <= s_centre;
        sensor_right  <= s_right;
        motor_select  <= sel;
        manual_value  <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic [9:0] raw_near(input int base, input int spread);
        return 10'(clamp_int(base + $urandom_range(0, 2 * spread) - spread, 0, 1023));
    endfunction

    // Random beat: mostly samples near the thresholds, with manual writes, stops and the unused kind mixed in.
    task automatic send_random_item();
        int          pick;
        logic [1:0]  k;
        logic [9:0]  s_left;
        logic [9:0]  s_centre;
        logic [9:0]  s_right;
        logic [7:0]  sel;
        logic [15:0] value;
        pick     = $urandom_range(0, 99);
        s_left   = 10'($urandom);
        s_centre = 10'($urandom);
        s_right  = 10'($urandom);
        sel      = 8'($urandom);
        value    = 16'($urandom);
        if (pick < 62)
            k = KIND_SAMPLE;
        else if (pick < 82)
            k = KIND_MANUAL;
        else if (pick < 95)
            k = KIND_STOP;
        else
            k = KIND_UNUSED;
        if (k == KIND_SAMPLE)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_left  = raw_near(bias_l + 50, 60);
                s_right = raw_near(bias_r + 50, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                s_centre = raw_near(bias_c + SENSE_MAX + 2, 5);
            else if (pick < 80)
                s_centre = raw_near(bias_c + 50, 50);
        end
        else if (k == KIND_MANUAL)
        begin
            if ($urandom_range(0, 1) == 0)
                sel = MOTOR_SEL_A;
            if ($urandom_range(0, 1) == 0)
                value = 16'($urandom_range(0, 600) - 300);
        end
        send_item(k, s_left, s_centre, s_right, sel, value);
    endtask

    // Lets the block drain so that settings can change while it is idle.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Settings beat; valid stays high so that beats can follow back to back.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] gp, input logic [15:0] gd,
                                  input logic [15:0] cs, input logic [15:0] bl,
                                  input logic [15:0] bc, input logic [15:0] br);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_CRUISE, cs);
        write_reg(CFG_BIAS_LEFT, bl);
        write_reg(CFG_BIAS_CENTRE, bc);
        write_reg(CFG_BIAS_RIGHT, br);
        cfg_valid <= 1'b0;
    endtask

    // Samples under the reset settings.
    task automatic test_reset_defaults();
        send_item(KIND_SAMPLE, 10'd103, 10'd100, 10'd0, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd0, 10'd99, 10'd98, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd1023, 10'd1023, 10'd1023, 8'd0, 16'd0);
    endtask

    // Field extremes, every kind, the one-shot stop report and the drive clamp.
    task automatic test_directed();
        quiesce();
        apply_settings(16'sd7, -16'sd3, 16'sd60, 16'sd3, 16'sd0, -16'sd2);
        send_item(KIND_SAMPLE, 10'd0, 10'd100, 10'd0, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd1023, 10'd100, 10'd0, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd0, 10'd100, 10'd1023, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd60, 10'd100, 10'd40, 8'd0, 16'd0);
        // Leaving the line reports once, and only once.
        send_item(KIND_SAMPLE, 10'd50, 10'd99, 10'd50, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd0, 10'd0, 10'd0, 8'd0, 16'd0);
        // Manual speeds beyond the drive range saturate.
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, MOTOR_SEL_A, 16'sd32767);
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, 8'd0, -16'sd32768);
        send_item(KIND_SAMPLE, 10'd200, 10'd50, 10'd300, 8'd0, 16'd0);
        send_item(KIND_MANUAL, 10'd1023, 10'd1023, 10'd1023, 8'd255, -16'sd200);
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, MOTOR_SEL_A, 16'sd1);
        send_item(KIND_SAMPLE, 10'd10, 10'd20, 10'd30, 8'd0, 16'd0);
        send_item(KIND_UNUSED, 10'd1023, 10'd100, 10'd0, MOTOR_SEL_A, 16'sd300);
        // Stop or go zeroes the manual speeds but keeps the report state.
        send_item(KIND_STOP, 10'd1023, 10'd1023, 10'd1023, 8'd255, 16'hFFFF);
        send_item(KIND_SAMPLE, 10'd7, 10'd3, 10'd9, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd1023, 10'd1000, 10'd0, 8'd0, 16'd0);
        send_item(KIND_SAMPLE, 10'd0, 10'd0, 10'd1023, 8'd0, 16'd0);
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, 8'd3, 16'sd255);
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, MOTOR_SEL_A, -16'sd255);
        send_item(KIND_SAMPLE, 10'd5, 10'd0, 10'd5, 8'd0, 16'd0);
        send_item(KIND_MANUAL, 10'd0, 10'd0, 10'd0, 8'd1, 16'sd256);
        send_item(KIND_SAMPLE, 10'd5, 10'd0, 10'd5, 8'd0, 16'd0);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_item();
    endtask

    // Random beats under several settings, the extremes among them.
    task automatic test_settings_sweep();
        quiesce();
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        apply_settings(16'sd4, 16'sd9, 16'sd40, 16'sd3, 16'sd0, -16'sd2);
        run_random(PHASE_ITEMS);
        quiesce();
        apply_settings(16'sd32767, 16'sd32767, 16'sd32767, 16'sd127, 16'sd127, 16'sd127);
        run_random(PHASE_ITEMS);
        quiesce();
        apply_settings(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd128, -16'sd128,
                       -16'sd128);
        run_random(PHASE_ITEMS);
        quiesce();
        apply_settings(-16'sd500, 16'sd1200, -16'sd100, -16'sd5, 16'sd10, 16'sd7);
        run_random(PHASE_ITEMS);
        quiesce();
        write_reg(CFG_SPARE_HI, 16'($urandom));
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        run_random(PHASE_ITEMS);
    endtask

    // Receiver holds off while samples keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        quiesce();
        apply_settings(16'sd12, -16'sd20, 16'sd70, 16'sd0, 16'sd0, 16'sd0);
        holds_asked <= holds_asked + 1;
        repeat (30)
            send_item(KIND_SAMPLE, 10'($urandom_range(0, 120)),
                      10'($urandom_range(95, 105)), 10'($urandom_range(0, 120)),
                      8'($urandom), 16'($urandom));
    endtask

    // A stretch with no idling on either side.
    task automatic test_unpaced_stream();
        quiesce();
        apply_settings(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        idle_on = 1'b0;
        run_random(PHASE_ITEMS);
        quiesce();
        idle_on = 1'b1;
    endtask

    // Test sequence and final verdict.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_settings_sweep();
        test_backpressure();
        test_unpaced_stream();
        quiesce();
        if (expected_drive.size() != 0)
            report_error($sformatf("%0d expected beats never arrived",
                                   expected_drive.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
